// File: hdl/pcts_pkg.sv
// ----------------------------------------------------------------------------
// pcts_pkg
// Types and codes shared by the periodic client tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package pcts_pkg;

  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_REG   = 3'd1,
    MODE_UNREG = 3'd2,
    MODE_SET   = 3'd3,
    MODE_GET   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_FIRED = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam logic REMOVE_BIT = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] client_id;
    logic [30:0] interval;
    logic [30:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] client_id_res;
    logic [30:0] interval_out;
    logic [1:0]  status;
    logic        last_of_run;
  } out_item_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [15:0] client;
    logic [30:0] period;
    logic [31:0] last_time;
    logic        remove_mark;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_REPLY,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: hdl/pcts_tick_eval.sv
// ----------------------------------------------------------------------------
// pcts_tick_eval
// Per-entry tick update: period reload and fire decision.
// ----------------------------------------------------------------------------
`default_nettype none
module pcts_tick_eval (
  input  wire pcts_pkg::entry_t ent,
  input  wire logic [30:0]      now,
  output pcts_pkg::entry_t      ent_new,
  output logic                  fire
);
  logic [31:0] last_adj;
  logic [32:0] sum;

  always_comb begin
    // last time later than now restarts the period
    if ($signed(ent.last_time) > $signed({1'b0, now})) begin
      last_adj = 32'd0 - {1'b0, ent.period};
    end else begin
      last_adj = ent.last_time;
    end
    sum = {2'b00, ent.period} + {last_adj[31], last_adj};
    fire = $signed(sum) < $signed({2'b00, now});
    ent_new = ent;
    ent_new.remove_mark = 1'b0;
    ent_new.last_time = fire ? {1'b0, now} : last_adj;
  end
endmodule
`default_nettype wire

// File: hdl/periodic_client_tick_scheduler_top.sv
// ----------------------------------------------------------------------------
// periodic_client_tick_scheduler_top
// Client table with register, unregister, set, get and tick operations.
// ----------------------------------------------------------------------------
// The client table sits in one synchronous memory of DEPTH entries. Every
// operation walks the table in order from entry zero and visits each entry
// in use in a read step and an evaluate step: one to issue the read and one
// to evaluate the data. The block takes the next item only once it is idle
// again after the last one is done. A tick emits one item per firing client,
// then an end-of-tick item. Every other operation emits one reply. Results
// pass through an output register. A stalled output holds the walk. Unknown
// modes are dropped with no result.
`default_nettype none
module periodic_client_tick_scheduler_top #(
  parameter int DEPTH = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire pcts_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output pcts_pkg::out_item_t  out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // table memory
  pcts_pkg::entry_t mem [DEPTH];
  pcts_pkg::entry_t rd_data;

  pcts_pkg::state_t state, state_next;
  pcts_pkg::in_item_t cur;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_idx, rd_idx_next;   // read index
  logic [CW-1:0] wr_idx, wr_idx_next;   // compaction write index
  logic          found, found_next;
  logic [30:0]   hit_period, hit_period_next;

  logic             rd_en;
  logic             we;
  logic [AW-1:0]    waddr;
  pcts_pkg::entry_t wdata;

  pcts_pkg::out_item_t out_next;
  logic                out_load;

  pcts_pkg::entry_t ev_ent;
  logic             ev_fire;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  pcts_tick_eval u_eval (
    .ent     (rd_data),
    .now     (cur.now),
    .ent_new (ev_ent),
    .fire    (ev_fire)
  );

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcts_pkg::S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= in_data;
    end
    rd_idx <= rd_idx_next;
    wr_idx <= wr_idx_next;
    found <= found_next;
    hit_period <= hit_period_next;
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // sequencer
  always_comb begin
    logic    match;
    logic    live;
    logic    ok;
    state_next = state;
    count_next = count;
    rd_idx_next = rd_idx;
    wr_idx_next = wr_idx;
    found_next = found;
    hit_period_next = hit_period;
    in_ready = 1'b0;
    rd_en = 1'b0;
    we = 1'b0;
    waddr = '0;
    wdata = ev_ent;
    out_load = 1'b0;
    out_next = '0;
    match = 1'b0;
    live = 1'b0;
    ok = 1'b0;
    case (state)
      pcts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        rd_idx_next = '0;
        wr_idx_next = '0;
        found_next = 1'b0;
        hit_period_next = '0;
        if (in_valid) begin
          if (in_data.mode <= pcts_pkg::MODE_GET) begin
            state_next = pcts_pkg::S_READ;
          end
        end
      end
      // issue read of rd_idx, or finish when past the end
      pcts_pkg::S_READ: begin
        if (rd_idx >= count) begin
          state_next = (cur.mode == pcts_pkg::MODE_TICK) ? pcts_pkg::S_DONE
                                                         : pcts_pkg::S_REPLY;
        end else begin
          rd_en = 1'b1;
          state_next = pcts_pkg::S_SCAN;
        end
      end
      // entry data available
      pcts_pkg::S_SCAN: begin
        match = rd_data.client == cur.client_id;
        live = rd_data.remove_mark != pcts_pkg::REMOVE_BIT;
        if (cur.mode == pcts_pkg::MODE_TICK) begin
          if (!live) begin
            rd_idx_next = rd_idx + 1'b1;
            state_next = pcts_pkg::S_READ;
          end else if (!ev_fire || out_free) begin
            we = 1'b1;
            waddr = wr_idx[AW-1:0];
            wdata = ev_ent;
            wr_idx_next = wr_idx + 1'b1;
            rd_idx_next = rd_idx + 1'b1;
            state_next = pcts_pkg::S_READ;
            if (ev_fire) begin
              out_load = 1'b1;
              out_next.kind = pcts_pkg::KIND_FIRED;
              out_next.client_id_res = rd_data.client;
            end
          end
        end else begin
          ok = match && (live || cur.mode == pcts_pkg::MODE_UNREG);
          if (ok && !found) begin
            found_next = 1'b1;
            hit_period_next = rd_data.period;
            if (cur.mode == pcts_pkg::MODE_UNREG) begin
              we = 1'b1;
              waddr = rd_idx[AW-1:0];
              wdata = rd_data;
              wdata.remove_mark = pcts_pkg::REMOVE_BIT;
            end else if (cur.mode == pcts_pkg::MODE_SET) begin
              we = 1'b1;
              waddr = rd_idx[AW-1:0];
              wdata = rd_data;
              wdata.period = cur.interval;
            end
          end
          rd_idx_next = rd_idx + 1'b1;
          state_next = pcts_pkg::S_READ;
        end
      end
      // single reply for non-tick operations
      pcts_pkg::S_REPLY: begin
        if (out_free) begin
          out_load = 1'b1;
          out_next.kind = pcts_pkg::KIND_REPLY;
          out_next.client_id_res = cur.client_id;
          out_next.last_of_run = 1'b1;
          out_next.status = pcts_pkg::ST_OK;
          state_next = pcts_pkg::S_IDLE;
          case (cur.mode)
            pcts_pkg::MODE_REG: begin
              if (found) begin
                out_next.status = pcts_pkg::ST_DUP;
              end else if (count >= CW'(DEPTH)) begin
                out_next.status = pcts_pkg::ST_FULL;
              end else begin
                we = 1'b1;
                waddr = count[AW-1:0];
                wdata.client = cur.client_id;
                wdata.period = cur.interval;
                wdata.last_time = 32'd0 - {1'b0, cur.interval};
                wdata.remove_mark = 1'b0;
                count_next = count + 1'b1;
              end
            end
            pcts_pkg::MODE_GET: begin
              if (found) begin
                out_next.interval_out = hit_period;
              end else begin
                out_next.status = pcts_pkg::ST_NOTFOUND;
              end
            end
            default: begin
              if (!found) begin
                out_next.status = pcts_pkg::ST_NOTFOUND;
              end
            end
          endcase
        end
      end
      // end of tick
      pcts_pkg::S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_next.kind = pcts_pkg::KIND_END;
          out_next.last_of_run = 1'b1;
          count_next = wr_idx;
          state_next = pcts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pcts_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // table never exceeds its depth
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("entry count above depth");
  // compaction never overtakes the read side
  a_compact: assert property (@(posedge clk) disable iff (rst)
    state == pcts_pkg::S_SCAN |-> wr_idx <= rd_idx)
    else $error("write index ahead of read index");
  // items taken only when idle
  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == pcts_pkg::S_IDLE)
    else $error("accept outside idle");
`endif

endmodule
`default_nettype wire

// File: tb/periodic_client_tick_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// periodic_client_tick_scheduler_top_tb
// Drives register, unregister, set, get and tick items into the client table
// and checks every result against a behavioral copy of the table kept here.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_client_tick_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = 16;
  localparam int EXP_DEPTH = 1024;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  pcts_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  pcts_pkg::out_item_t out_data;

  periodic_client_tick_scheduler_top #(.DEPTH(TBL_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // model of the client table
  logic [15:0] tbl_client [TBL_DEPTH];
  logic [30:0] tbl_period [TBL_DEPTH];
  logic [31:0] tbl_last   [TBL_DEPTH];
  logic        tbl_mark   [TBL_DEPTH];
  int          tbl_count;

  // expected results, written by the sender, consumed by the checker
  pcts_pkg::out_item_t exp_buf [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int mismatches = 0;
  int send_idle_pct;
  int recv_stall_pct;
  // hold-off request from the tests, served by the receiver process
  int hold_off_req = 0;
  int hold_off_len = 0;
  int hold_off_seen = 0;
  int hold_off_cycles = 0;

  function automatic pcts_pkg::out_item_t mk_res(logic [1:0] kind, logic [15:0] id,
                                                 logic [30:0] iv, logic [1:0] st);
    pcts_pkg::out_item_t r;
    r.kind = kind; r.client_id_res = id; r.interval_out = iv;
    r.status = st; r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic int find_client(logic [15:0] id, bit live_only);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_client[i] == id && (!live_only || !tbl_mark[i])) return i;
    return -1;
  endfunction

  // queue one expected result
  task automatic expect_result(logic [1:0] kind, logic [15:0] id, logic [30:0] iv,
                               logic [1:0] st);
    exp_buf[exp_wr % EXP_DEPTH] = mk_res(kind, id, iv, st);
    exp_wr++;
  endtask

  // compute the results of one item and update the table copy
  task automatic predict_schedule(pcts_pkg::in_item_t it);
    int first;
    int w;
    int idx;
    logic signed [32:0] sum;
    first = exp_wr;
    case (it.mode)
      pcts_pkg::MODE_TICK: begin
        w = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_mark[i]) begin
            tbl_client[w] = tbl_client[i];
            tbl_period[w] = tbl_period[i];
            tbl_last[w]   = tbl_last[i];
            tbl_mark[w]   = 1'b0;
            if ($signed(tbl_last[w]) > $signed({1'b0, it.now}))
              tbl_last[w] = -{1'b0, tbl_period[w]};
            sum = $signed({2'b00, tbl_period[w]})
                  + $signed({tbl_last[w][31], tbl_last[w]});
            if (sum < $signed({2'b00, it.now})) begin
              expect_result(pcts_pkg::KIND_FIRED, tbl_client[w], '0, pcts_pkg::ST_OK);
              tbl_last[w] = {1'b0, it.now};
            end
            w++;
          end
        end
        tbl_count = w;
        expect_result(pcts_pkg::KIND_END, '0, '0, pcts_pkg::ST_OK);
      end
      pcts_pkg::MODE_REG: begin
        if (find_client(it.client_id, 1) >= 0)
          expect_result(pcts_pkg::KIND_REPLY, it.client_id, '0, pcts_pkg::ST_DUP);
        else if (tbl_count >= TBL_DEPTH)
          expect_result(pcts_pkg::KIND_REPLY, it.client_id, '0, pcts_pkg::ST_FULL);
        else begin
          tbl_client[tbl_count] = it.client_id;
          tbl_period[tbl_count] = it.interval;
          tbl_last[tbl_count]   = -{1'b0, it.interval};
          tbl_mark[tbl_count]   = 1'b0;
          tbl_count++;
          expect_result(pcts_pkg::KIND_REPLY, it.client_id, '0, pcts_pkg::ST_OK);
        end
      end
      pcts_pkg::MODE_UNREG: begin
        idx = find_client(it.client_id, 0);
        if (idx >= 0) begin
          tbl_mark[idx] = 1'b1;
          expect_result(pcts_pkg::KIND_REPLY, it.client_id, '0, pcts_pkg::ST_OK);
        end else
          expect_result(pcts_pkg::KIND_REPLY, it.client_id, '0, pcts_pkg::ST_NOTFOUND);
      end
      pcts_pkg::MODE_SET: begin
        idx = find_client(it.client_id, 1);
        if (idx >= 0) begin
          tbl_period[idx] = it.interval;
          expect_result(pcts_pkg::KIND_REPLY, it.client_id, '0, pcts_pkg::ST_OK);
        end else
          expect_result(pcts_pkg::KIND_REPLY, it.client_id, '0, pcts_pkg::ST_NOTFOUND);
      end
      pcts_pkg::MODE_GET: begin
        idx = find_client(it.client_id, 1);
        if (idx >= 0)
          expect_result(pcts_pkg::KIND_REPLY, it.client_id, tbl_period[idx],
                        pcts_pkg::ST_OK);
        else
          expect_result(pcts_pkg::KIND_REPLY, it.client_id, '0, pcts_pkg::ST_NOTFOUND);
      end
      default: ;
    endcase
    if (exp_wr != first) exp_buf[(exp_wr - 1) % EXP_DEPTH].last_of_run = 1'b1;
  endtask

  // send one item, predicting it at acceptance
  task automatic send_item(logic [2:0] mode, logic [15:0] id, logic [30:0] iv,
                           logic [30:0] now);
    pcts_pkg::in_item_t it;
    it.mode = mode; it.client_id = id; it.interval = iv; it.now = now;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_schedule(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver ready with random stalls and long hold-offs
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off_seen != hold_off_req) begin
      hold_off_seen <= hold_off_req;
      hold_off_cycles <= hold_off_len;
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    pcts_pkg::out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (exp_rd == exp_wr) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_r = exp_buf[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch expected %p actual %p", exp_r, out_data);
        end
      end
    end
  end

  // random operation biased to a small id pool so hits are common
  task automatic send_random(int n);
    logic [2:0] m;
    logic [15:0] id;
    logic [30:0] iv;
    logic [30:0] tnow;
    for (int i = 0; i < n; i++) begin
      m = 3'($urandom_range(99) < 4 ? $urandom_range(5, 7) : $urandom_range(0, 4));
      id = ($urandom_range(9) < 8) ? 16'($urandom_range(20)) : 16'($urandom);
      case ($urandom_range(3))
        0: iv = 31'($urandom_range(50));
        1: iv = 31'($urandom_range(2000));
        2: iv = 31'h7fffffff - 31'($urandom_range(3));
        default: iv = 31'($urandom);
      endcase
      tnow = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(5000));
      send_item(m, id, iv, tnow);
    end
  endtask

  task automatic test_directed();
    send_item(pcts_pkg::MODE_TICK, 16'h0, 31'h0, 31'h0);
    send_item(pcts_pkg::MODE_GET, 16'h5, 31'h0, 31'h0);
    send_item(pcts_pkg::MODE_SET, 16'h5, 31'h7, 31'h0);
    send_item(pcts_pkg::MODE_UNREG, 16'hffff, 31'h0, 31'h0);
    send_item(pcts_pkg::MODE_REG, 16'h0, 31'h0, 31'h0);
    send_item(pcts_pkg::MODE_REG, 16'hffff, 31'h7fffffff, 31'h0);
    send_item(pcts_pkg::MODE_REG, 16'h0, 31'h3, 31'h0);
    send_item(3'd5, 16'h1, 31'h1, 31'h1);
    send_item(3'd7, 16'h1, 31'h1, 31'h1);
    send_item(pcts_pkg::MODE_GET, 16'hffff, 31'h0, 31'h0);
    send_item(pcts_pkg::MODE_TICK, 16'h0, 31'h0, 31'h7fffffff);
    send_item(pcts_pkg::MODE_TICK, 16'h0, 31'h0, 31'h5);
    send_item(pcts_pkg::MODE_SET, 16'h0, 31'h2, 31'h0);
    send_item(pcts_pkg::MODE_UNREG, 16'h0, 31'h0, 31'h0);
    send_item(pcts_pkg::MODE_UNREG, 16'h0, 31'h0, 31'h0);
    send_item(pcts_pkg::MODE_REG, 16'h0, 31'h9, 31'h0);
    send_item(pcts_pkg::MODE_GET, 16'h0, 31'h0, 31'h0);
    send_item(pcts_pkg::MODE_TICK, 16'h0, 31'h0, 31'h10);
    // fill the table; the last of the loop and one more get a full status
    for (int i = 1; i <= 15; i++)
      send_item(pcts_pkg::MODE_REG, 16'(i * 4099), 31'(i), 31'h0);
    send_item(pcts_pkg::MODE_REG, 16'h1234, 31'h1, 31'h0);
    send_item(pcts_pkg::MODE_TICK, 16'h0, 31'h0, 31'h7fffffff);
  endtask

  task automatic test_full_table_fire();
    for (int i = 0; i < 16; i++)
      send_item(pcts_pkg::MODE_UNREG, 16'(i * 4099), 31'h0, 31'h0);
    send_item(pcts_pkg::MODE_TICK, 16'h0, 31'h0, 31'h0);
    for (int i = 0; i < 16; i++)
      send_item(pcts_pkg::MODE_REG, 16'(i + 100), 31'(i), 31'h0);
    send_item(pcts_pkg::MODE_TICK, 16'h0, 31'h0, 31'h20);
  endtask

  task automatic test_backpressure();
    hold_off_len = 400;
    hold_off_req++;
    send_random(20);
    send_item(pcts_pkg::MODE_TICK, 16'h0, 31'h0, 31'h7fffffff);
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(90);
    send_idle_pct = 75; recv_stall_pct = 0;  send_random(60);
    send_idle_pct = 0;  recv_stall_pct = 75; send_random(60);
    wait_drained();
    send_idle_pct = 19; recv_stall_pct = 19; send_random(60);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    tbl_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table_fire();
    test_backpressure();
    test_random_phases();
    wait_drained();
    if (mismatches == 0 && exp_rd == exp_wr)
      $display("periodic_client_tick_scheduler_top verification clean");
    else
      $display("periodic_client_tick_scheduler_top verification failed");
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("periodic_client_tick_scheduler_top verification failed");
    $finish;
  end
endmodule
`default_nettype wire
